// ===== sv/csq_pkg.sv =====
// ----------------------------------------------------------------------------
// csq_pkg
// Shared types and constants for the contactor sequencer.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam logic [1:0] CMD_RX   = 2'd0;
    localparam logic [1:0] CMD_MGMT = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_TLM  = 2'd3;

    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_CHG_V   = 3'd1;
    localparam logic [2:0] REG_CHG_I   = 3'd2;
    localparam logic [2:0] REG_CHG_PER = 3'd3;
    localparam logic [2:0] REG_HB_PER  = 3'd4;

    localparam logic [10:0] ID_SYNC   = 11'd128;
    localparam logic [10:0] ID_REQ    = 11'd144;
    localparam logic [10:0] ID_STATE  = 11'd145;
    localparam logic [10:0] ID_VOLT   = 11'd146;
    localparam logic [10:0] ID_TEMP   = 11'd147;
    localparam logic [10:0] ID_CURR   = 11'd148;
    localparam logic [10:0] ID_FAULT  = 11'd149;
    localparam logic [10:0] ID_CHG    = 11'd157;
    localparam logic [10:0] ID_ONB    = 11'd158;
    localparam logic [10:0] ID_HB     = 11'd159;

    localparam logic [7:0] REQ_CODE_PRE    = 8'd6;
    localparam logic [7:0] REQ_CODE_CLOSE  = 8'd3;
    localparam logic [7:0] REQ_CODE_PRE_CH = 8'd8;
    localparam logic [7:0] REQ_CODE_CL_CH  = 8'd9;
    localparam logic [7:0] REQ_CODE_OPEN   = 8'd0;

    localparam logic [1:0] MODE_PRE    = 2'd0;
    localparam logic [1:0] MODE_CLOSED = 2'd1;
    localparam logic [1:0] MODE_OPEN   = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [10:0] rx_cob_id;
        logic [15:0] rx_word;
        logic [3:0]  tlm_idx;
        logic [23:0] tlm_val;
    } t_item;

    typedef struct packed {
        logic        tx_valid;
        logic [1:0]  tx_mailbox;
        logic [3:0]  tx_length;
        logic [10:0] tx_cob_id;
        logic [63:0] tx_payload;
        logic        last;
        logic        minus_c;
        logic        plus_c;
        logic        pre_relay;
        logic        led;
        logic [2:0]  code;
    } t_result;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        swap16 = {v[7:0], v[15:8]};
    endfunction

endpackage

// ===== sv/csq_queue.sv =====
// ----------------------------------------------------------------------------
// csq_queue
// Small item queue between the front end and the executor.
// ----------------------------------------------------------------------------
module csq_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  csq_pkg::t_item  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output csq_pkg::t_item  o_data
);
    import csq_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == QAW'(0) + (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push && !o_full) - (QAW+1)'(i_pop && !o_empty);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !o_empty) else $error("full and empty together");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push && !i_pop) |=> $stable(r_cnt)) else $error("count moved when idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH)) else $error("count overflow");
endmodule

// ===== sv/csq_exec.sv =====
// ----------------------------------------------------------------------------
// csq_exec
// Executes one item: updates state and emits its frames one per cycle while i_res_ready is high.
// ----------------------------------------------------------------------------
module csq_exec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [23:0]       i_cfg_data,
    input  logic              i_q_empty,
    input  csq_pkg::t_item    i_q_data,
    output logic              o_q_pop,
    output logic              o_res_valid,
    output csq_pkg::t_result  o_res,
    input  logic              i_res_ready
);
    import csq_pkg::*;

    // configuration
    logic [15:0] r_timeout, r_chg_v;
    logic [7:0]  r_chg_i, r_chg_per, r_hb_per;

    // sequencer state
    logic [1:0]  r_mode;
    logic        r_armed, r_announced, r_sync, r_lamp;
    logic [4:0]  r_req;
    logic [15:0] r_timer;
    logic [3:0]  r_fslot;
    logic [7:0]  r_cslot, r_hslot, r_hval;
    logic [23:0] r_tlm [16];

    // frame list built for the current item, then drained
    logic [7:0]  r_fv;
    logic [1:0]  r_fmb  [8];
    logic [3:0]  r_flen [8];
    logic [10:0] r_fid  [8];
    logic [63:0] r_fpl  [8];
    logic        r_busy;
    logic [2:0]  r_ptr;

    // ---- combinational evaluation of one item ----
    logic [1:0]  n_mode;
    logic        n_armed, n_announced, n_sync, n_lamp;
    logic [4:0]  n_req;
    logic [15:0] n_timer;
    logic [3:0]  n_fslot;
    logic [7:0]  n_cslot, n_hslot, n_hval;
    logic [7:0]  n_fv;
    logic [1:0]  n_fmb  [8];
    logic [3:0]  n_flen [8];
    logic [10:0] n_fid  [8];
    logic [63:0] n_fpl  [8];
    logic [3:0]  k;
    logic [7:0]  code;
    logic [2:0]  mcode;

    function automatic logic [2:0] mode_code(input logic [1:0] m);
        mode_code = (m == MODE_PRE) ? 3'd6 : (m == MODE_CLOSED) ? 3'd3 : 3'd0;
    endfunction

    always_comb begin
        n_mode = r_mode; n_armed = r_armed; n_announced = r_announced;
        n_sync = r_sync; n_lamp = r_lamp; n_req = r_req; n_timer = r_timer;
        n_fslot = r_fslot; n_cslot = r_cslot; n_hslot = r_hslot; n_hval = r_hval;
        n_fv = '0;
        for (int i = 0; i < 8; i++) begin
            n_fmb[i] = '0; n_flen[i] = '0; n_fid[i] = '0; n_fpl[i] = '0;
        end
        k = '0;
        code = i_q_data.rx_word[15:8];
        mcode = '0;
        unique case (i_q_data.cmd)
            CMD_RX: begin
                if (i_q_data.rx_cob_id == ID_SYNC) n_sync = 1'b1;
                if (i_q_data.rx_cob_id == ID_REQ) begin
                    priority case (code)
                        REQ_CODE_PRE:    begin n_req[0] = 1'b1; n_lamp = 1'b1; end
                        REQ_CODE_CLOSE:  begin n_req[1] = 1'b1; n_lamp = 1'b1; end
                        REQ_CODE_PRE_CH: begin n_req[2] = 1'b1; n_lamp = 1'b0; end
                        REQ_CODE_CL_CH:  begin n_req[3] = 1'b1; n_lamp = 1'b1; end
                        REQ_CODE_OPEN:   begin n_req[4] = 1'b1; n_lamp = 1'b0; end
                        default: ;
                    endcase
                end
            end
            CMD_MGMT: begin
                if ((n_req[0] && !n_armed) || n_req[2]) begin
                    n_mode = MODE_PRE; n_req[0] = 1'b0; n_req[2] = 1'b0; n_armed = 1'b1;
                    n_fv[k[2:0]] = 1'b1; n_fmb[k[2:0]] = 2'd1; n_flen[k[2:0]] = 4'd1;
                    n_fid[k[2:0]] = ID_STATE; n_fpl[k[2:0]] = 64'd6; k = k + 4'd1;
                    n_announced = 1'b0; n_lamp = 1'b1;
                end
                if ((n_req[1] && n_armed) || n_req[3]) begin
                    n_mode = MODE_CLOSED; n_req[1] = 1'b0; n_req[3] = 1'b0;
                    n_fv[k[2:0]] = 1'b1; n_fmb[k[2:0]] = 2'd1; n_flen[k[2:0]] = 4'd1;
                    n_fid[k[2:0]] = ID_STATE; n_fpl[k[2:0]] = 64'd3; k = k + 4'd1;
                    n_announced = 1'b0; n_lamp = 1'b1;
                end
                if (r_timer > r_timeout || n_req[4]) begin
                    if (!n_announced) begin
                        n_fv[k[2:0]] = 1'b1; n_fmb[k[2:0]] = 2'd1; n_flen[k[2:0]] = 4'd1;
                        n_fid[k[2:0]] = ID_STATE; n_fpl[k[2:0]] = 64'd0; k = k + 4'd1;
                    end
                    n_mode = MODE_OPEN; n_req[4] = 1'b0; n_armed = 1'b0;
                    n_announced = 1'b1; n_lamp = 1'b0;
                end
                if (r_sync) begin
                    n_timer = '0; n_sync = 1'b0;
                    mcode = mode_code(n_mode);
                    if (r_fslot == 4'd1) begin
                        n_fv[k[2:0]] = 1'b1; n_fmb[k[2:0]] = 2'd1; n_flen[k[2:0]] = 4'd1;
                        n_fid[k[2:0]] = ID_STATE; n_fpl[k[2:0]] = {61'd0, mcode};
                        k = k + 4'd1;
                    end
                    if (r_fslot >= 4'd2 && r_fslot <= 4'd12 && !r_fslot[0]) begin
                        n_fv[k[2:0]] = 1'b1; n_fmb[k[2:0]] = 2'd0; n_flen[k[2:0]] = 4'd7;
                        n_fid[k[2:0]] = ID_VOLT;
                        n_fpl[k[2:0]] = {8'd0, swap16(r_tlm[2][15:0]), r_tlm[2][23:16],
                                         swap16(r_tlm[1][15:0]), swap16(r_tlm[0][15:0])};
                        k = k + 4'd1;
                        n_fv[k[2:0]] = 1'b1; n_fmb[k[2:0]] = 2'd1; n_flen[k[2:0]] = 4'd8;
                        n_fid[k[2:0]] = ID_CURR;
                        n_fpl[k[2:0]] = {swap16(r_tlm[6][15:0]), swap16(r_tlm[5][15:0]),
                                         swap16(r_tlm[4][15:0]), swap16(r_tlm[3][15:0])};
                        k = k + 4'd1;
                    end
                    if (r_fslot >= 4'd3 && r_fslot <= 4'd11 && r_fslot[0]) begin
                        n_fv[k[2:0]] = 1'b1; n_fmb[k[2:0]] = 2'd0; n_flen[k[2:0]] = 4'd6;
                        n_fid[k[2:0]] = ID_TEMP;
                        n_fpl[k[2:0]] = {16'd0, swap16(r_tlm[9][15:0]),
                                         swap16(r_tlm[8][15:0]), swap16(r_tlm[7][15:0])};
                        k = k + 4'd1;
                        n_fv[k[2:0]] = 1'b1; n_fmb[k[2:0]] = 2'd1; n_flen[k[2:0]] = 4'd6;
                        n_fid[k[2:0]] = ID_ONB;
                        n_fpl[k[2:0]] = {16'd0, swap16(r_tlm[12][15:0]),
                                         swap16(r_tlm[11][15:0]), swap16(r_tlm[10][15:0])};
                        k = k + 4'd1;
                    end
                    if (r_fslot == 4'd12) begin
                        n_fslot = 4'd1;
                        n_cslot = r_cslot + 8'd1;
                    end else begin
                        n_fslot = r_fslot + 4'd1;
                    end
                    n_fv[k[2:0]] = 1'b1; n_fmb[k[2:0]] = 2'd2; n_flen[k[2:0]] = 4'd4;
                    n_fid[k[2:0]] = ID_FAULT;
                    n_fpl[k[2:0]] = {40'd0, r_tlm[15][7:0], r_tlm[14][7:0], r_tlm[13][7:0]};
                    k = k + 4'd1;
                    if (n_cslot == r_chg_per) begin
                        n_cslot = '0;
                        n_fv[k[2:0]] = 1'b1; n_fmb[k[2:0]] = 2'd0; n_flen[k[2:0]] = 4'd3;
                        n_fid[k[2:0]] = ID_CHG;
                        n_fpl[k[2:0]] = {40'd0, r_chg_i, swap16(r_chg_v)};
                        k = k + 4'd1;
                    end
                    if (r_hslot == r_hb_per) begin
                        n_fv[k[2:0]] = 1'b1; n_fmb[k[2:0]] = 2'd3; n_flen[k[2:0]] = 4'd1;
                        n_fid[k[2:0]] = ID_HB; n_fpl[k[2:0]] = {56'd0, r_hval};
                        n_hval = (r_hval >= 8'd254) ? 8'd0 : r_hval + 8'd1;
                        n_hslot = 8'd1;
                    end else begin
                        n_hslot = r_hslot + 8'd1;
                    end
                end
                if (n_mode == MODE_OPEN) begin
                    n_armed = 1'b0; n_lamp = 1'b0;
                end else begin
                    n_lamp = 1'b1;
                end
            end
            CMD_TICK: begin
                if (r_timer != 16'hFFFF) n_timer = r_timer + 16'd1;
            end
            CMD_TLM: ;
            default: ;
        endcase
    end

    // ---- output side ----
    logic       more;
    logic [2:0] ptr_nx;
    assign ptr_nx = r_ptr + 3'd1;
    assign more   = (r_ptr != 3'd7) && r_fv[ptr_nx];

    assign o_res_valid = r_busy;
    always_comb begin
        o_res.tx_valid   = r_fv[r_ptr];
        o_res.tx_mailbox = r_fmb[r_ptr];
        o_res.tx_length  = r_flen[r_ptr];
        o_res.tx_cob_id  = r_fid[r_ptr];
        o_res.tx_payload = r_fpl[r_ptr];
        o_res.last       = !more;
        o_res.minus_c    = (r_mode != MODE_OPEN) && (r_mode != 2'd3);
        o_res.plus_c     = (r_mode == MODE_CLOSED);
        o_res.pre_relay  = (r_mode == MODE_PRE);
        o_res.led        = r_lamp;
        o_res.code       = mode_code(r_mode);
    end

    logic take;
    assign take    = !i_q_empty && (!r_busy || (i_res_ready && !more));
    assign o_q_pop = take;

    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int i = 0; i < 8; i++) begin
                r_fmb[i] <= n_fmb[i]; r_flen[i] <= n_flen[i];
                r_fid[i] <= n_fid[i]; r_fpl[i] <= n_fpl[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd4000; r_chg_v <= '0; r_chg_i <= '0;
            r_chg_per <= 8'd20; r_hb_per <= 8'd4;
            r_mode <= MODE_OPEN; r_armed <= 1'b0; r_announced <= 1'b0;
            r_sync <= 1'b0; r_lamp <= 1'b0; r_req <= '0; r_timer <= '0;
            r_fslot <= '0; r_cslot <= '0; r_hslot <= '0; r_hval <= '0;
            r_fv <= '0; r_busy <= 1'b0; r_ptr <= '0;
            for (int i = 0; i < 16; i++) r_tlm[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TIMEOUT: r_timeout <= i_cfg_data[15:0];
                    REG_CHG_V:   r_chg_v   <= i_cfg_data[15:0];
                    REG_CHG_I:   r_chg_i   <= i_cfg_data[7:0];
                    REG_CHG_PER: r_chg_per <= i_cfg_data[7:0];
                    REG_HB_PER:  r_hb_per  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (take && i_q_data.cmd == CMD_TLM) r_tlm[i_q_data.tlm_idx] <= i_q_data.tlm_val;
            if (take) begin
                r_mode <= n_mode; r_armed <= n_armed; r_announced <= n_announced;
                r_sync <= n_sync; r_lamp <= n_lamp; r_req <= n_req; r_timer <= n_timer;
                r_fslot <= n_fslot; r_cslot <= n_cslot; r_hslot <= n_hslot;
                r_hval <= n_hval; r_fv <= n_fv; r_busy <= 1'b1; r_ptr <= '0;
            end else if (r_busy && i_res_ready) begin
                if (more) r_ptr <= ptr_nx;
                else r_busy <= 1'b0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_res_ready) |=> $stable(r_ptr)) else $error("frame pointer moved in stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hval != 8'd255) else $error("heartbeat value out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_ptr != 3'd0 |-> r_fv[r_ptr]) else $error("drained an empty frame");
endmodule

// ===== sv/csq_out.sv =====
// ----------------------------------------------------------------------------
// csq_out
// Two-entry result buffer presenting the output queue interface.
// ----------------------------------------------------------------------------
module csq_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  csq_pkg::t_result  i_data,
    output logic              o_ready,
    output logic              o_empty,
    output csq_pkg::t_result  o_data,
    input  logic              i_pop
);
    import csq_pkg::*;

    t_result    r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_buf[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) r_buf[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("result buffer overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> $stable(o_data)) else $error("head changed while held");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> !o_empty) else $error("write lost");
endmodule

// ===== sv/contactor_sequencer_with_telemetry_top.sv =====
// ----------------------------------------------------------------------------
// contactor_sequencer_with_telemetry_top
// Battery contactor sequencer with periodic telemetry frame generation.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive the item fields and push; a transaction is taken
//   when push is high and full is low. A four-entry queue decouples the
//   front from the executor, so items are taken back to back while it has room.
//   Result queue: while empty is low the oldest result sits on the o_ ports;
//   pop takes it. Every item yields one to eight results; the final one has
//   o_last set. A step with no frame gives one result with o_tx_valid low.
//   Timing: an item is evaluated combinationally when it leaves the queue,
//   and its results are registered in the executor, then in the result buffer.
//   Result rate: one result per cycle while the result buffer has room; the
//   executor takes the next item as the last result of the current one leaves.
//   Configuration: i_cfg_valid/o_cfg_ready with register index and data;
//   always ready. Write only while idle.
//   Reset (synchronous, i_rst_n low): registers to defaults, contactors open,
//   queues empty. A stalled result side backs up into the input queue, which
//   then raises full; nothing is dropped.
// ----------------------------------------------------------------------------
module contactor_sequencer_with_telemetry_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [10:0] i_rx_cob_id,
    input  logic [15:0] i_rx_word,
    input  logic [3:0]  i_telemetry_index,
    input  logic [23:0] i_telemetry_value,
    output logic        empty,
    input  logic        pop,
    output logic        o_tx_valid,
    output logic [1:0]  o_tx_mailbox,
    output logic [3:0]  o_tx_length,
    output logic [10:0] o_tx_cob_id,
    output logic [63:0] o_tx_payload,
    output logic        o_last,
    output logic        o_minus_contactor,
    output logic        o_plus_contactor,
    output logic        o_precharge_relay,
    output logic        o_status_led,
    output logic [2:0]  o_contactor_code
);
    import csq_pkg::*;

    t_item   in_item, q_item;
    t_result ex_res, out_res;
    logic    q_empty, q_pop, ex_valid, ob_ready;

    assign o_cfg_ready = 1'b1;

    // pack the input transaction
    assign in_item.cmd       = i_cmd;
    assign in_item.rx_cob_id = i_rx_cob_id;
    assign in_item.rx_word   = i_rx_word;
    assign in_item.tlm_idx   = i_telemetry_index;
    assign in_item.tlm_val   = i_telemetry_value;

    // front: item queue
    csq_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push (push), .i_data (in_item), .o_full (full),
        .i_pop (q_pop), .o_empty (q_empty), .o_data (q_item)
    );

    // back: state update and frame drain
    csq_exec u_exec (
        .i_clk, .i_rst_n,
        .i_cfg_we (i_cfg_valid), .i_cfg_idx (i_cfg_index), .i_cfg_data (i_cfg_data),
        .i_q_empty (q_empty), .i_q_data (q_item), .o_q_pop (q_pop),
        .o_res_valid (ex_valid), .o_res (ex_res), .i_res_ready (ob_ready)
    );

    // result buffer toward the consumer
    csq_out u_out (
        .i_clk, .i_rst_n,
        .i_valid (ex_valid), .i_data (ex_res), .o_ready (ob_ready),
        .o_empty (empty), .o_data (out_res), .i_pop (pop)
    );

    assign o_tx_valid        = out_res.tx_valid;
    assign o_tx_mailbox      = out_res.tx_mailbox;
    assign o_tx_length       = out_res.tx_length;
    assign o_tx_cob_id       = out_res.tx_cob_id;
    assign o_tx_payload      = out_res.tx_payload;
    assign o_last            = out_res.last;
    assign o_minus_contactor = out_res.minus_c;
    assign o_plus_contactor  = out_res.plus_c;
    assign o_precharge_relay = out_res.pre_relay;
    assign o_status_led      = out_res.led;
    assign o_contactor_code  = out_res.code;
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the contactor sequencer: a built-in predictor
// follows each accepted item and a scoreboard compares every popped result.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import csq_pkg::*;

    // Predicted frame set per item, kept in arrival order.
    class frame_scoreboard;
        t_result pending_q[$];
        int      mismatches;
        int      checked;

        function void note_item(ref t_result res[$]);
            foreach (res[k]) pending_q.push_back(res[k]);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: expected %h, got %h", checked, want, got);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    logic        push = 0;
    logic        full;
    logic [1:0]  i_cmd = '0;
    logic [10:0] i_rx_cob_id = '0;
    logic [15:0] i_rx_word = '0;
    logic [3:0]  i_telemetry_index = '0;
    logic [23:0] i_telemetry_value = '0;
    logic        empty;
    logic        pop = 0;
    t_result     got;

    contactor_sequencer_with_telemetry_top dut (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .push, .full, .i_cmd, .i_rx_cob_id, .i_rx_word, .i_telemetry_index,
        .i_telemetry_value, .empty, .pop,
        .o_tx_valid(got.tx_valid), .o_tx_mailbox(got.tx_mailbox),
        .o_tx_length(got.tx_length), .o_tx_cob_id(got.tx_cob_id),
        .o_tx_payload(got.tx_payload), .o_last(got.last),
        .o_minus_contactor(got.minus_c), .o_plus_contactor(got.plus_c),
        .o_precharge_relay(got.pre_relay), .o_status_led(got.led),
        .o_contactor_code(got.code)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- predictor state ----------------
    logic [15:0] p_timeout;
    logic [15:0] p_chg_v;
    logic [7:0]  p_chg_i;
    logic [7:0]  p_chg_per;
    logic [7:0]  p_hb_per;
    logic [1:0]  p_mode;
    logic        p_armed, p_announced, p_sync, p_lamp;
    logic [4:0]  p_req;          // precharge, close, charger pre, charger close, open
    logic [15:0] p_alive;
    logic [3:0]  p_slot;
    logic [7:0]  p_chg_slot, p_hb_slot, p_hb_val;
    logic [23:0] p_tlm [16];
    t_result     frames_q[$];

    frame_scoreboard sb = new();

    function automatic logic [63:0] put8(logic [7:0] v, int pos);
        return 64'(v) << (8 * pos);
    endfunction

    // 16-bit values go out high byte first
    function automatic logic [63:0] put16(logic [15:0] v, int pos);
        return put8(v[15:8], pos) | put8(v[7:0], pos + 1);
    endfunction

    function automatic void add_frame(logic [1:0] mb, logic [3:0] len,
                                      logic [10:0] id, logic [63:0] pl);
        t_result r;
        r = '0;
        r.tx_valid = 1'b1; r.tx_mailbox = mb; r.tx_length = len;
        r.tx_cob_id = id; r.tx_payload = pl;
        if (frames_q.size() < 8) frames_q.push_back(r);
    endfunction

    function automatic logic [2:0] state_code();
        return p_mode == MODE_PRE ? 3'd6 : (p_mode == MODE_CLOSED ? 3'd3 : 3'd0);
    endfunction

    task automatic model_reset();
        p_timeout = 16'd4000; p_chg_v = '0; p_chg_i = '0; p_chg_per = 8'd20;
        p_hb_per = 8'd4;
        p_mode = MODE_OPEN; p_armed = 1'b0; p_announced = 1'b0; p_req = '0; p_sync = 1'b0;
        p_alive = '0; p_slot = '0; p_chg_slot = '0; p_hb_slot = '0; p_hb_val = '0;
        p_lamp = 1'b0;
        foreach (p_tlm[k]) p_tlm[k] = '0;
    endtask

    task automatic send_sync_frames();
        p_alive = '0;
        p_sync = 1'b0;
        if (p_slot == 4'd1) add_frame(2'd1, 4'd1, ID_STATE, 64'(state_code()));
        if (p_slot >= 4'd2 && p_slot <= 4'd12 && !p_slot[0]) begin
            add_frame(2'd0, 4'd7, ID_VOLT, put16(p_tlm[0][15:0], 0) | put16(p_tlm[1][15:0], 2)
                      | put8(p_tlm[2][23:16], 4) | put16(p_tlm[2][15:0], 5));
            add_frame(2'd1, 4'd8, ID_CURR, put16(p_tlm[3][15:0], 0) | put16(p_tlm[4][15:0], 2)
                      | put16(p_tlm[5][15:0], 4) | put16(p_tlm[6][15:0], 6));
        end
        if (p_slot >= 4'd3 && p_slot <= 4'd11 && p_slot[0]) begin
            add_frame(2'd0, 4'd6, ID_TEMP, put16(p_tlm[7][15:0], 0) | put16(p_tlm[8][15:0], 2)
                      | put16(p_tlm[9][15:0], 4));
            add_frame(2'd1, 4'd6, ID_ONB, put16(p_tlm[10][15:0], 0) | put16(p_tlm[11][15:0], 2)
                      | put16(p_tlm[12][15:0], 4));
        end
        if (p_slot == 4'd12) begin
            p_slot = '0;
            p_chg_slot++;
        end
        p_slot++;
        add_frame(2'd2, 4'd4, ID_FAULT, put8(p_tlm[13][7:0], 0) | put8(p_tlm[14][7:0], 1)
                  | put8(p_tlm[15][7:0], 2));
        if (p_chg_slot == p_chg_per) begin
            p_chg_slot = '0;
            add_frame(2'd0, 4'd3, ID_CHG, put16(p_chg_v, 0) | put8(p_chg_i, 2));
        end
        if (p_hb_slot == p_hb_per) begin
            p_hb_slot = '0;
            add_frame(2'd3, 4'd1, ID_HB, put8(p_hb_val, 0));
            p_hb_val++;
            if (p_hb_val == 8'd255) p_hb_val = '0;
        end
        p_hb_slot++;
    endtask

    task automatic manage_pass();
        if ((p_req[0] && !p_armed) || p_req[2]) begin
            p_mode = MODE_PRE; p_req[0] = 1'b0; p_req[2] = 1'b0; p_armed = 1'b1;
            add_frame(2'd1, 4'd1, ID_STATE, 64'(REQ_CODE_PRE));
            p_announced = 1'b0; p_lamp = 1'b1;
        end
        if ((p_req[1] && p_armed) || p_req[3]) begin
            p_mode = MODE_CLOSED; p_req[1] = 1'b0; p_req[3] = 1'b0;
            add_frame(2'd1, 4'd1, ID_STATE, 64'(REQ_CODE_CLOSE));
            p_announced = 1'b0; p_lamp = 1'b1;
        end
        if (p_alive > p_timeout || p_req[4]) begin
            if (!p_announced) add_frame(2'd1, 4'd1, ID_STATE, 64'(REQ_CODE_OPEN));
            p_mode = MODE_OPEN; p_req[4] = 1'b0; p_armed = 1'b0; p_announced = 1'b1;
            p_lamp = 1'b0;
        end
        if (p_sync) send_sync_frames();
        if (p_mode == MODE_PRE || p_mode == MODE_CLOSED) p_lamp = 1'b1;
        else if (p_mode == MODE_OPEN) begin
            p_armed = 1'b0; p_lamp = 1'b0;
        end
    endtask

    // Work out every result one item causes and hand them to the scoreboard.
    task automatic predict_item(t_item it);
        logic [7:0] code;
        int n;
        frames_q.delete();
        case (it.cmd)
            CMD_RX: begin
                code = it.rx_word[15:8];
                if (it.rx_cob_id == ID_SYNC) p_sync = 1'b1;
                if (it.rx_cob_id == ID_REQ) begin
                    if (code == REQ_CODE_PRE) begin p_req[0] = 1'b1; p_lamp = 1'b1; end
                    else if (code == REQ_CODE_CLOSE) begin p_req[1] = 1'b1; p_lamp = 1'b1; end
                    else if (code == REQ_CODE_PRE_CH) begin p_req[2] = 1'b1; p_lamp = 1'b0; end
                    else if (code == REQ_CODE_CL_CH) begin p_req[3] = 1'b1; p_lamp = 1'b1; end
                    else if (code == REQ_CODE_OPEN) begin p_req[4] = 1'b1; p_lamp = 1'b0; end
                end
            end
            CMD_MGMT: manage_pass();
            CMD_TICK: if (p_alive != 16'hFFFF) p_alive++;
            default:  p_tlm[it.tlm_idx] = it.tlm_val;
        endcase
        if (frames_q.size() == 0) frames_q.push_back('0);
        n = frames_q.size();
        foreach (frames_q[k]) begin
            frames_q[k].last      = (k == n - 1);
            frames_q[k].minus_c   = (p_mode != MODE_OPEN);
            frames_q[k].plus_c    = (p_mode == MODE_CLOSED);
            frames_q[k].pre_relay = (p_mode == MODE_PRE);
            frames_q[k].led       = p_lamp;
            frames_q[k].code      = state_code();
        end
        sb.note_item(frames_q);
    endtask

    // ---------------- drivers ----------------
    bit gaps_on = 1;       // random idling on both sides
    bit hold_pop = 0;      // long receiver hold-off
    int sent_items;
    int syncs_sent;

    // push stays high after a transaction so items can go back to back
    task automatic push_item(t_item it);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_cmd <= it.cmd; i_rx_cob_id <= it.rx_cob_id; i_rx_word <= it.rx_word;
        i_telemetry_index <= it.tlm_idx; i_telemetry_value <= it.tlm_val;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_item(it);
        sent_items++;
        if (it.cmd == CMD_RX && it.rx_cob_id == ID_SYNC) syncs_sent++;
    endtask

    task automatic stop_push();
        push <= 1'b0;
    endtask

    // valid stays high between back-to-back writes; caller drops it
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_TIMEOUT: p_timeout = val[15:0];
            REG_CHG_V:   p_chg_v = val[15:0];
            REG_CHG_I:   p_chg_i = val[7:0];
            REG_CHG_PER: p_chg_per = val[7:0];
            REG_HB_PER:  p_hb_per = val[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_item mk(logic [1:0] c, logic [10:0] id, logic [15:0] w,
                                 logic [3:0] ti, logic [23:0] tv);
        t_item it;
        it.cmd = c; it.rx_cob_id = id; it.rx_word = w; it.tlm_idx = ti; it.tlm_val = tv;
        return it;
    endfunction

    // A mostly well-formed item: requests, syncs, passes, ticks, telemetry.
    function automatic t_item rand_item();
        logic [7:0] codes [6] = '{REQ_CODE_PRE, REQ_CODE_CLOSE, REQ_CODE_PRE_CH,
                                   REQ_CODE_CL_CH, REQ_CODE_OPEN, 8'd5};
        t_item it;
        it = mk(2'($urandom_range(0, 3)), 11'($urandom), 16'($urandom),
                4'($urandom), 24'($urandom));
        case ($urandom_range(0, 9))
            0, 1: begin it.cmd = CMD_RX; it.rx_cob_id = ID_SYNC; end
            2, 3: begin
                it.cmd = CMD_RX; it.rx_cob_id = ID_REQ;
                it.rx_word[15:8] = codes[$urandom_range(0, 5)];
            end
            4, 5: it.cmd = CMD_MGMT;
            6:    it.cmd = CMD_TICK;
            default: ;   // fully random noise, any command
        endcase
        return it;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_pop || (gaps_on && $urandom_range(0, 7) == 0)) begin
                pop <= 0;
                gap = hold_pop ? 0 : $urandom_range(1, 16);
                repeat (gap) @(posedge i_clk);
            end else begin
                pop <= 1;
            end
        end
    end

    // sample on every edge where a result transaction completes
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_result(got);
    end

    int cycles;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [23:0] reg_vals [5];
        t_item it;
        model_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: telemetry extremes, all request codes, one sync
        for (int k = 0; k < 16; k += 5) push_item(mk(CMD_TLM, '0, '0, 4'(k), 24'hFFFFFF));
        push_item(mk(CMD_TLM, 11'h7FF, 16'hFFFF, 4'd15, 24'hA5A5A5));
        push_item(mk(CMD_RX, ID_REQ, {REQ_CODE_CLOSE, 8'hFF}, '0, '0)); // close before precharge
        push_item(mk(CMD_MGMT, '0, '0, '0, '0));
        push_item(mk(CMD_RX, ID_REQ, {REQ_CODE_PRE, 8'h00}, '0, '0));
        push_item(mk(CMD_MGMT, '0, '0, '0, '0));
        push_item(mk(CMD_RX, ID_REQ, {REQ_CODE_PRE, 8'h00}, '0, '0));   // precharge while armed
        push_item(mk(CMD_MGMT, '0, '0, '0, '0));
        push_item(mk(CMD_RX, ID_REQ, {8'hFF, 8'h00}, '0, '0));          // unknown code
        push_item(mk(CMD_RX, 11'h7FF, {REQ_CODE_OPEN, 8'h00}, '0, '0)); // other id
        push_item(mk(CMD_RX, ID_REQ, {REQ_CODE_OPEN, 8'h00}, '0, '0));
        push_item(mk(CMD_MGMT, '0, '0, '0, '0));
        push_item(mk(CMD_RX, ID_REQ, {REQ_CODE_OPEN, 8'h00}, '0, '0));  // already announced
        push_item(mk(CMD_RX, ID_REQ, {REQ_CODE_PRE_CH, 8'h00}, '0, '0));
        push_item(mk(CMD_RX, ID_REQ, {REQ_CODE_CL_CH, 8'h00}, '0, '0));
        push_item(mk(CMD_RX, ID_SYNC, '0, '0, '0));
        push_item(mk(CMD_MGMT, '0, '0, '0, '0));
        push_item(mk(CMD_TICK, '0, '0, '0, '0));
        stop_push();
        wait_drained();

        // long receiver hold-off while the sender keeps offering items
        hold_pop = 1;
        fork
            begin
                repeat (12) push_item(mk(CMD_RX, ID_SYNC, '0, '0, '0));
                repeat (10) begin
                    push_item(mk(CMD_MGMT, '0, '0, '0, '0));
                    push_item(mk(CMD_RX, ID_SYNC, '0, '0, '0));
                end
                stop_push();
            end
            begin
                repeat (300) @(posedge i_clk);
                hold_pop = 0;
            end
        join
        wait_drained();

        // several settings, extremes included; every register written
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: reg_vals = '{24'd0, 24'hFFFF, 24'hFF, 24'd1, 24'd1};
                1: reg_vals = '{24'hFFFF, 24'd0, 24'd0, 24'd255, 24'd255};
                2: reg_vals = '{24'd3, 24'h1234, 24'h5A, 24'd0, 24'd0};
                3: reg_vals = '{24'($urandom_range(0, 20)), 24'($urandom), 24'($urandom),
                                24'd2, 24'd3};
                default: reg_vals = '{24'd4000, 24'hABCD, 24'h81, 24'd20, 24'd4};
            endcase
            for (int r = 0; r < 5; r++) write_reg(3'(r), reg_vals[r]);
            write_reg(3'd7, 24'hFFFFFF);   // out-of-range index
            i_cfg_valid <= 1'b0;
            if (phase == 4) gaps_on = 0;
            repeat (phase == 1 ? 130 : 80) begin
                it = rand_item();
                // extra ticks in the phase whose timeout is 0xFFFF
                if (phase == 1 && $urandom_range(0, 3) == 0) it.cmd = CMD_TICK;
                push_item(it);
            end
            stop_push();
            wait_drained();
        end

        $display("covered %0d items, %0d syncs, %0d results checked, 5 register settings",
                 sent_items, syncs_sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
